>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker module.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with an active-low asynchronous reset disable
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication whose consequent is checked in the next cycle
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/khp_pkg.sv
// Types, register codes and constants for the k-space high-pass mask.
// No dependencies.
package khp_pkg;

	localparam int DATA_W  = 32;
	localparam int IDX_W   = 12;
	localparam int GAIN_W  = 17;
	localparam int ADDR_W  = 5;
	localparam logic [12:0] ROWS_RESET = 13'd4096;
	localparam logic [16:0] GAIN_ONE   = 17'd65536;
	localparam logic [16:0] LOG2E_Q16  = 17'd94548;

	// Register indexes (byte address / 4)
	localparam logic [2:0] REG_ROW_COUNT  = 3'd0;
	localparam logic [2:0] REG_CUT_DIST2  = 3'd1;
	localparam logic [2:0] REG_ZERO_DIST2 = 3'd2;
	localparam logic [2:0] REG_CUT_DIST   = 3'd3;
	localparam logic [2:0] REG_GAUSS      = 3'd4;
	localparam logic [2:0] REG_APODIZE    = 3'd5;

	typedef enum logic [1:0] {
		SEL_ZERO,
		SEL_UNITY,
		SEL_TAPER
	} gain_sel_t;

	typedef struct packed {
		logic [IDX_W-1:0]         row_index;
		logic [IDX_W-1:0]         col_index;
		logic signed [DATA_W-1:0] bin_re;
		logic signed [DATA_W-1:0] bin_im;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] out_re;
		logic signed [DATA_W-1:0] out_im;
		logic [GAIN_W-1:0]        gain;
	} rsp_t;

	// 2^(-k/16) in Q.16, k = 0..16
	function automatic logic [16:0] pow2_neg(input logic [4:0] k);
		logic [16:0] v;
		case (k)
			5'd0:  v = 17'd65536;
			5'd1:  v = 17'd62757;
			5'd2:  v = 17'd60097;
			5'd3:  v = 17'd57549;
			5'd4:  v = 17'd55109;
			5'd5:  v = 17'd52773;
			5'd6:  v = 17'd50535;
			5'd7:  v = 17'd48393;
			5'd8:  v = 17'd46341;
			5'd9:  v = 17'd44376;
			5'd10: v = 17'd42495;
			5'd11: v = 17'd40693;
			5'd12: v = 17'd38968;
			5'd13: v = 17'd37316;
			5'd14: v = 17'd35734;
			5'd15: v = 17'd34219;
			default: v = 17'd32768;
		endcase
		return v;
	endfunction

endpackage

>>> hw/rtl/kspace_highpass_mask.sv
// One request per cycle sustained while the result side is ready.
// Throughput is set by a fully pipelined datapath: the square root runs as
// seven stages of three digits each, and each multiply step has its own stage.
// A stall at the result side fills bubbles first, then holds the pipeline.
// Reset clears all valid bits and loads the register defaults (row count 4096).
module kspace_highpass_mask import khp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              req_valid,
	output logic              req_ready,
	input  req_t              req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rsp_t              rsp
);

	localparam int NST   = 18;
	localparam int SQ_N  = 8;
	localparam int REM_W = 26;
	localparam int D2_W  = 25;

	typedef struct packed {
		logic signed [DATA_W-1:0] re;
		logic signed [DATA_W-1:0] im;
		logic                     dc;
		gain_sel_t                sel;
	} carry_t;

	// Configuration registers
	logic [12:0] row_count_q;
	logic [31:0] cut_dist2_q, zero_dist2_q, gauss_coeff_q;
	logic [19:0] cut_dist_q;
	logic        apodize_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q   <= ROWS_RESET;
			cut_dist2_q   <= '0;
			zero_dist2_q  <= '0;
			cut_dist_q    <= '0;
			gauss_coeff_q <= '0;
			apodize_q     <= 1'b0;
		end else if (wr_en) begin
			case (paddr[4:2])
				REG_ROW_COUNT:  row_count_q   <= pwdata[12:0];
				REG_CUT_DIST2:  cut_dist2_q   <= pwdata;
				REG_ZERO_DIST2: zero_dist2_q  <= pwdata;
				REG_CUT_DIST:   cut_dist_q    <= pwdata[19:0];
				REG_GAUSS:      gauss_coeff_q <= pwdata;
				REG_APODIZE:    apodize_q     <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (paddr[4:2])
			REG_ROW_COUNT:  prdata = {19'd0, row_count_q};
			REG_CUT_DIST2:  prdata = cut_dist2_q;
			REG_ZERO_DIST2: prdata = zero_dist2_q;
			REG_CUT_DIST:   prdata = {12'd0, cut_dist_q};
			REG_GAUSS:      prdata = gauss_coeff_q;
			REG_APODIZE:    prdata = {31'd0, apodize_q};
			default:        prdata = '0;
		endcase
	end

	// Stage valids and enables: a stage loads when empty or when its successor moves
	logic [NST-1:0] vld_s;
	logic [NST:0]   en;
	carry_t         cr_s [NST];
	carry_t         cr_d;

	always_comb begin
		en[NST] = rsp_ready;
		for (int k = NST - 1; k >= 0; k--)
			en[k] = !vld_s[k] || en[k+1];
	end

	assign req_ready = en[0];
	assign rsp_valid = vld_s[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) vld_s[0] <= req_valid;
			for (int k = 1; k < NST; k++)
				if (en[k]) vld_s[k] <= vld_s[k-1];
		end
	end

	// Carry the bin and its gain selection down the pipeline
	always_ff @(posedge clk) begin
		for (int k = 1; k < NST; k++)
			if (en[k]) cr_s[k] <= (k == 2) ? cr_d : cr_s[k-1];
		if (en[0]) begin
			cr_s[0].re  <= req.bin_re;
			cr_s[0].im  <= req.bin_im;
			cr_s[0].dc  <= (req.row_index == '0) && (req.col_index == '0);
			cr_s[0].sel <= SEL_ZERO;
		end
	end

	// Stage 1: fold the row index
	logic [11:0] fold_s1, col_s1;
	logic [11:0] fold_d;
	logic [12:0] row_ext;

	always_comb begin
		row_ext = {1'b0, req.row_index};
		if (row_ext <= {1'b0, row_count_q[12:1]})
			fold_d = req.row_index;
		else if (row_ext <= row_count_q)
			fold_d = 12'(row_count_q - row_ext);
		else
			fold_d = req.row_index;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			fold_s1 <= fold_d;
			col_s1  <= req.col_index;
		end
	end

	// Stage 2: squared radius
	logic [D2_W-1:0] d2_s2;

	always_ff @(posedge clk) begin
		if (en[1])
			d2_s2 <= D2_W'({13'd0, fold_s1} * {13'd0, fold_s1})
				+ D2_W'({13'd0, col_s1} * {13'd0, col_s1});
	end

	// Stage 3: region select and square root set-up
	logic [REM_W-1:0] sq_rem_s  [SQ_N];
	logic [20:0]      sq_root_s [SQ_N];
	logic [41:0]      sq_v_s    [SQ_N];
	logic [33:0]      d2q;
	gain_sel_t        sel_d;

	always_comb begin
		d2q = {1'b0, d2_s2, 8'd0};
		if (cr_s[1].dc)
			sel_d = SEL_ZERO;
		else if (d2q > {2'd0, cut_dist2_q})
			sel_d = SEL_UNITY;
		else if (!apodize_q)
			sel_d = SEL_ZERO;
		else if (d2q <= {2'd0, zero_dist2_q})
			sel_d = SEL_ZERO;
		else
			sel_d = SEL_TAPER;
	end

	// Merge the selection into the carried bin
	always_comb begin
		cr_d     = cr_s[1];
		cr_d.sel = sel_d;
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			sq_rem_s[0]  <= '0;
			sq_root_s[0] <= '0;
			sq_v_s[0]    <= {1'b0, d2_s2, 16'd0};
		end
	end

	// Stages 4 to 10: three square root digits per stage
	logic [REM_W-1:0] rem_n  [SQ_N];
	logic [20:0]      root_n [SQ_N];
	logic [41:0]      v_n    [SQ_N];

	always_comb begin
		logic [REM_W-1:0] rem, trial;
		logic [20:0]      root;
		logic [41:0]      v;
		for (int j = 0; j < SQ_N; j++) begin
			rem_n[j]  = '0;
			root_n[j] = '0;
			v_n[j]    = '0;
		end
		for (int j = 1; j < SQ_N; j++) begin
			rem  = sq_rem_s[j-1];
			root = sq_root_s[j-1];
			v    = sq_v_s[j-1];
			for (int i = 0; i < 3; i++) begin
				rem   = {rem[REM_W-3:0], v[41:40]};
				v     = {v[39:0], 2'b00};
				trial = {3'd0, root, 2'b01};
				if (rem >= trial) begin
					rem  = rem - trial;
					root = {root[19:0], 1'b1};
				end else begin
					root = {root[19:0], 1'b0};
				end
			end
			rem_n[j]  = rem;
			root_n[j] = root;
			v_n[j]    = v;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 1; j < SQ_N; j++) begin
			if (en[2+j]) begin
				sq_rem_s[j]  <= rem_n[j];
				sq_root_s[j] <= root_n[j];
				sq_v_s[j]    <= v_n[j];
			end
		end
	end

	// Stage 11: distance from the cutoff edge, squared
	logic [39:0] rel2_s11;
	logic [19:0] rel_d;

	assign rel_d = ({1'b0, cut_dist_q} > sq_root_s[SQ_N-1])
		? 20'({1'b0, cut_dist_q} - sq_root_s[SQ_N-1]) : '0;

	always_ff @(posedge clk) begin
		if (en[10]) rel2_s11 <= {20'd0, rel_d} * {20'd0, rel_d};
	end

	// Stage 12: scale by the decay rate, split in two halves
	logic [55:0] pa_s12, pb_s12;

	always_ff @(posedge clk) begin
		if (en[11]) begin
			pa_s12 <= {16'd0, rel2_s11} * {40'd0, gauss_coeff_q[31:16]};
			pb_s12 <= {16'd0, rel2_s11} * {40'd0, gauss_coeff_q[15:0]};
		end
	end

	// Stage 13: recombine to Q.16 exponent, flag the underflow range
	logic [20:0] x_s13;
	logic        xbig_s13;
	logic [56:0] lo_sum;
	logic [48:0] x_full;

	assign lo_sum = {33'd0, pa_s12[7:0], 16'd0} + {1'b0, pb_s12};
	assign x_full = {1'b0, pa_s12[55:8]} + {16'd0, lo_sum[56:24]};

	always_ff @(posedge clk) begin
		if (en[12]) begin
			x_s13    <= x_full[20:0];
			xbig_s13 <= |x_full[48:21];
		end
	end

	// Stage 14: convert to base two
	logic [21:0] y_s14;
	logic        xbig_s14;
	logic [37:0] y_full;

	assign y_full = {17'd0, x_s13} * {21'd0, LOG2E_Q16};

	always_ff @(posedge clk) begin
		if (en[13]) begin
			y_s14    <= y_full[37:16];
			xbig_s14 <= xbig_s13;
		end
	end

	// Stage 15: interpolate 2^-frac from the table
	logic [16:0] mant_s15;
	logic [5:0]  yi_s15;
	logic        xbig_s15;
	logic [16:0] tlo, thi;
	logic [23:0] ip;
	logic [24:0] ip_r;

	assign tlo  = pow2_neg({1'b0, y_s14[15:12]});
	assign thi  = pow2_neg(5'({1'b0, y_s14[15:12]} + 5'd1));
	assign ip   = {12'd0, 12'(tlo - thi)} * {12'd0, y_s14[11:0]};
	assign ip_r = {1'b0, ip} + 25'd2048;

	always_ff @(posedge clk) begin
		if (en[14]) begin
			mant_s15 <= tlo - {4'd0, ip_r[24:12]};
			yi_s15   <= y_s14[21:16];
			xbig_s15 <= xbig_s14;
		end
	end

	// Stage 16: integer shift and final gain choice
	logic [GAIN_W-1:0] gain_s16;
	logic [GAIN_W-1:0] taper;

	assign taper = (xbig_s15 || yi_s15 >= 6'd17) ? '0 : (mant_s15 >> yi_s15);

	always_ff @(posedge clk) begin
		if (en[15]) begin
			case (cr_s[14].sel)
				SEL_UNITY: gain_s16 <= GAIN_ONE;
				SEL_TAPER: gain_s16 <= taper;
				default:   gain_s16 <= '0;
			endcase
		end
	end

	// Stage 17: apply gain
	logic signed [DATA_W+GAIN_W:0] pre_s17, pim_s17;
	logic [GAIN_W-1:0]             gain_s17;

	always_ff @(posedge clk) begin
		if (en[16]) begin
			pre_s17  <= cr_s[15].re * $signed({1'b0, gain_s16});
			pim_s17  <= cr_s[15].im * $signed({1'b0, gain_s16});
			gain_s17 <= gain_s16;
		end
	end

	// Stage 18: round half up and drop the fraction
	logic signed [DATA_W+GAIN_W:0] rre, rim;
	rsp_t                          rsp_s18;

	assign rre = pre_s17 + (DATA_W+GAIN_W+1)'(32768);
	assign rim = pim_s17 + (DATA_W+GAIN_W+1)'(32768);

	always_ff @(posedge clk) begin
		if (en[17]) begin
			rsp_s18.out_re <= rre[DATA_W+15:16];
			rsp_s18.out_im <= rim[DATA_W+15:16];
			rsp_s18.gain   <= gain_s17;
		end
	end

	assign rsp = rsp_s18;

endmodule

>>> hw/rtl/khp_checker.sv
// Port-level checks for the k-space high-pass mask, bound to the top level.
// Depends on khp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module khp_checker import khp_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input rsp_t              rsp
);

	// Hold a stalled result
	`CHK_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "result dropped while stalled")
	// Gain never exceeds unity
	`CHK_ASSERT(a_gain_range, clk, arst_n, rsp_valid |-> rsp.gain <= GAIN_ONE, "gain above unity")
	// Zero gain clears both parts
	`CHK_ASSERT(a_zero_out, clk, arst_n, rsp_valid && rsp.gain == '0 |-> rsp.out_re == '0 && rsp.out_im == '0, "zero gain left a nonzero bin")
	// Free result side never blocks requests
	`CHK_ASSERT(a_no_block, clk, arst_n, rsp_ready |-> req_ready, "requests blocked with free output")

endmodule

bind kspace_highpass_mask khp_checker u_khp_checker (.*);

>>> tb/tb_kspace_highpass_mask.sv
// Self-checking bench for the k-space high-pass mask: random and directed bins
// through the request/result handshake, checked against a bit-exact gain model.
// Depends on khp_pkg and kspace_highpass_mask.
module tb_kspace_highpass_mask;
	import khp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 18;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              req_valid = 1'b0;
	logic              req_ready;
	req_t              req = '0;
	logic              rsp_valid;
	logic              rsp_ready = 1'b0;
	rsp_t              rsp;

	// Mirror of the mask registers
	logic [12:0] m_rows;
	logic [31:0] m_cut2, m_zero2, m_gcoef;
	logic [19:0] m_cut;
	logic        m_apod;

	req_t   bin_queue[$];
	rsp_t   masked_queue[$];
	int     err_count = 0;
	int     bins_checked = 0;
	int     n_unity = 0, n_zero = 0, n_taper = 0;
	int     hold_off = 0;
	int     send_gap = 0, recv_gap = 0;
	logic [16:0] tab[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
		46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

	kspace_highpass_mask DUT (.*);

	always #5 clk = ~clk;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("MISMATCH %s: got %0h expected %0h (bin %0d)", what, got, want, bins_checked);
		err_count++;
	endtask

	function automatic logic [63:0] isqrt(input logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [16:0] taper_gain(input logic [63:0] d2);
		logic [63:0] rq, rel, rel2, a, b, x, y, yi, yf, lo, hi, v;
		rq = isqrt(d2 << 16);
		rel = (64'(m_cut) > rq) ? 64'(m_cut) - rq : 0;
		rel2 = rel * rel;
		a = rel2 * 64'(m_gcoef[31:16]);
		b = rel2 * 64'(m_gcoef[15:0]);
		x = (a >> 8) + ((((a & 64'hFF) << 16) + b) >> 24);
		if (x >= (64'd32 << 16)) return 0;
		y = (x * 64'd94548) >> 16;
		yi = y >> 16;
		if (yi >= 17) return 0;
		yf = y & 64'hFFFF;
		lo = 64'(tab[yf >> 12]);
		hi = 64'(tab[(yf >> 12) + 1]);
		v = lo - (((lo - hi) * (yf & 64'hFFF) + 2048) >> 12);
		return 17'(v >> yi);
	endfunction

	function automatic logic [31:0] scale(input logic signed [31:0] raw, input logic [16:0] g);
		logic signed [63:0] p;
		p = 64'(raw) * $signed({47'd0, g}) + 64'sd32768;
		return 32'(p >>> 16);
	endfunction

	// Work out the masked bin for one request
	function automatic rsp_t mask_bin(input req_t r);
		logic [63:0] row, col, nx, fold, d2, d2q;
		logic [16:0] g;
		rsp_t o;
		row = 64'(r.row_index);
		col = 64'(r.col_index);
		nx = 64'(m_rows);
		if (row <= nx / 2) fold = row;
		else if (row <= nx) fold = nx - row;
		else fold = row;
		d2 = fold * fold + col * col;
		d2q = d2 << 8;
		if (row == 0 && col == 0) g = 0;
		else if (d2q > 64'(m_cut2)) g = GAIN_ONE;
		else if (!m_apod) g = 0;
		else if (d2q <= 64'(m_zero2)) g = 0;
		else g = taper_gain(d2);
		o.out_re = scale(r.bin_re, g);
		o.out_im = scale(r.bin_im, g);
		o.gain = g;
		return o;
	endfunction

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_ROW_COUNT:  m_rows = val[12:0];
			REG_CUT_DIST2:  m_cut2 = val;
			REG_ZERO_DIST2: m_zero2 = val;
			REG_CUT_DIST:   m_cut = val[19:0];
			REG_GAUSS:      m_gcoef = val;
			default:        m_apod = val[0];
		endcase
	endtask

	// Set up a taper around radius rad (bins) with stop radius zr
	task automatic set_mask(input int rows, input int rad, input int zr, input logic [31:0] gc,
			input bit apod);
		reg_write(REG_ROW_COUNT, rows);
		reg_write(REG_CUT_DIST2, (rad * rad) << 8);
		reg_write(REG_ZERO_DIST2, (zr * zr) << 8);
		reg_write(REG_CUT_DIST, rad << 8);
		reg_write(REG_GAUSS, gc);
		reg_write(REG_APODIZE, {31'd0, apod});
	endtask

	function automatic req_t rand_bin(input int rmax, input int cmax);
		req_t r;
		r.row_index = 12'($urandom_range(rmax, 0));
		r.col_index = 12'($urandom_range(cmax, 0));
		r.bin_re = $urandom;
		r.bin_im = $urandom;
		return r;
	endfunction

	task automatic drain();
		while (bin_queue.size() != 0 || masked_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// Driver: present queued requests with random gaps
	always @(posedge clk) begin
		if (req_valid && req_ready) begin
			masked_queue.push_back(mask_bin(req));
			void'(bin_queue.pop_front());
			send_gap = $urandom_range(19, 0) * ($urandom_range(3, 0) == 0);
		end
		if (!(req_valid && !req_ready)) begin
			if (send_gap > 0) begin
				send_gap--;
				req_valid <= 1'b0;
			end else if (bin_queue.size() > 0) begin
				req_valid <= 1'b1;
				req <= bin_queue[0];
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Monitor: check results against the oldest expectation and stall at random
	always @(posedge clk) begin
		if (rsp_valid && rsp_ready) begin
			if (masked_queue.size() == 0) begin
				report("unexpected result", {47'd0, rsp.gain}, '0);
			end else begin
				rsp_t w;
				w = masked_queue.pop_front();
				if (rsp.out_re !== w.out_re)
					report("out_re", {32'd0, rsp.out_re}, {32'd0, w.out_re});
				if (rsp.out_im !== w.out_im)
					report("out_im", {32'd0, rsp.out_im}, {32'd0, w.out_im});
				if (rsp.gain !== w.gain) report("gain", {47'd0, rsp.gain}, {47'd0, w.gain});
				if (w.gain == GAIN_ONE) n_unity++;
				else if (w.gain == 0) n_zero++;
				else n_taper++;
			end
			bins_checked++;
			recv_gap = $urandom_range(19, 0) * ($urandom_range(3, 0) == 0);
		end
		if (hold_off > 0) begin
			hold_off--;
			rsp_ready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	initial begin
		req_t r;
		m_rows = ROWS_RESET; m_cut2 = 0; m_zero2 = 0; m_cut = 0; m_gcoef = 0; m_apod = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: reset settings, field extremes, DC bin
		bin_queue.push_back('{12'd0, 12'd0, 32'sh7FFFFFFF, 32'sh80000000});
		bin_queue.push_back('{12'd4095, 12'd4095, 32'sh80000000, 32'sh7FFFFFFF});
		bin_queue.push_back('{12'd0, 12'd1, -32'sd1, 32'sd1});
		drain();

		// Directed: taper band, hard cutoff, folding corners
		set_mask(64, 20, 4, 32'h0003_0000, 1);
		bin_queue.push_back('{12'd0, 12'd0, 32'sd100, 32'sd100});
		bin_queue.push_back('{12'd64, 12'd0, 32'sd12345, -32'sd12345});
		bin_queue.push_back('{12'd32, 12'd0, 32'sh7FFFFFFF, 32'sh80000000});
		bin_queue.push_back('{12'd33, 12'd0, 32'sd3, -32'sd3});
		bin_queue.push_back('{12'd65, 12'd0, 32'sd7, 32'sd7});
		bin_queue.push_back('{12'd0, 12'd20, 32'sd1, -32'sd1});
		bin_queue.push_back('{12'd0, 12'd21, 32'sd5, 32'sd5});
		bin_queue.push_back('{12'd0, 12'd4, -32'sd77, 32'sd77});
		for (int i = 5; i < 20; i += 3) bin_queue.push_back('{12'd0, 12'(i), 32'sh7FFFFFFF,
			32'sh80000000});
		drain();
		// Stop radius above cutoff, inconsistent cutoff, empty row count
		set_mask(0, 10, 30, 32'hFFFF_FFFF, 1);
		reg_write(REG_CUT_DIST, 0);
		for (int i = 0; i < 6; i++) bin_queue.push_back(rand_bin(15, 15));
		drain();
		reg_write(REG_ZERO_DIST2, 0);
		for (int i = 0; i < 6; i++) bin_queue.push_back(rand_bin(15, 15));
		drain();

		// Random phases over several settings
		for (int ph = 0; ph < 7; ph++) begin
			int rad, rows;
			rows = (ph == 0) ? 4096 : (ph == 1) ? 1 : $urandom_range(4096, 2);
			rad = (ph == 2) ? 0 : $urandom_range(60, 2);
			set_mask(rows, rad, $urandom_range(rad, 0), (ph == 3) ? 32'hFFFF_FFFF :
				$urandom_range(32'h0100_0000, 0), ph != 4);
			if (ph == 5) reg_write(REG_CUT_DIST2, 32'hFFFF_FFFF);
			for (int i = 0; i < 200; i++) begin
				int span;
				span = ($urandom_range(9, 0) == 0) ? 4095 : rad + 4;
				r = rand_bin(span, span);
				if ($urandom_range(7, 0) == 0)
					r.row_index = 12'(rows - int'($urandom_range(rad + 2, 0)));
				bin_queue.push_back(r);
				// Long receiver hold-off while requests stay queued
				if (ph == 1 && i == 20) hold_off = 200;
			end
			drain();
		end
		$display("Checked %0d masked bins: %0d passed, %0d zeroed, %0d tapered", bins_checked,
			n_unity, n_zero, n_taper);
		$display("Covered reset, hard cutoff, taper, folding and register extremes");
		if (err_count == 0 && masked_queue.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("Timeout after %0d bins", bins_checked);
		$display("Test completed with failures");
		$finish;
	end
endmodule
